@@ design/cldd_pkg.sv @@
// shared types, codes and constants for the cheat line decrypt and decode block
package cldd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 28;
  localparam int unsigned ROM_W = 26;
  localparam int unsigned OFF_W = 25;
  localparam int unsigned ST_W = 4;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  localparam logic [31:0] KEY0_RST = 32'h09F4_FBBD;
  localparam logic [31:0] KEY1_RST = 32'h9681_884A;
  localparam logic [31:0] KEY2_RST = 32'h3520_27E9;
  localparam logic [31:0] KEY3_RST = 32'hF3DE_E5A7;
  localparam logic [ROM_W-1:0] ROM_BYTES_RST = '0;

  localparam logic [31:0] GAME_ID_MARK = 32'h001D_C0DE;
  localparam logic [31:0] MASTER_MARK = 32'hDEAD_FACE;
  localparam logic [11:0] BUTTON_TOP_A = 12'h8A1;
  localparam logic [11:0] BUTTON_TOP_B = 12'h8A2;
  localparam logic [31:0] BUTTON_LINE = 32'h80F0_0000;
  localparam logic [7:0] COND_MULTI_TOP = 8'hE0;
  localparam logic [2:0] HOOK_SPACE = 3'b100;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES = 3'd4;

  // line types, top nibble of the plain left word
  localparam logic [3:0] TYPE_W8 = 4'h0;
  localparam logic [3:0] TYPE_W16 = 4'h1;
  localparam logic [3:0] TYPE_W32 = 4'h2;
  localparam logic [3:0] TYPE_GROUP = 4'h3;
  localparam logic [3:0] TYPE_PATCH = 4'h6;
  localparam logic [3:0] TYPE_BUTTON = 4'h8;
  localparam logic [3:0] TYPE_COND = 4'hD;
  localparam logic [3:0] TYPE_COND_MULTI = 4'hE;
  localparam logic [3:0] TYPE_HOOK = 4'hF;

  localparam logic [ST_W-1:0] ST_OK = 4'd0;
  localparam logic [ST_W-1:0] ST_MASTER = 4'd1;
  localparam logic [ST_W-1:0] ST_WIDE = 4'd2;
  localparam logic [ST_W-1:0] ST_WADDR = 4'd3;
  localparam logic [ST_W-1:0] ST_GROUP = 4'd4;
  localparam logic [ST_W-1:0] ST_PTYPE = 4'd5;
  localparam logic [ST_W-1:0] ST_PRANGE = 4'd6;
  localparam logic [ST_W-1:0] ST_BUTTON = 4'd7;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 4'd8;
  localparam logic [ST_W-1:0] ST_CVALUE = 4'd9;
  localparam logic [ST_W-1:0] ST_CADDR = 4'd10;
  localparam logic [ST_W-1:0] ST_CCMD = 4'd11;
  localparam logic [ST_W-1:0] ST_CEMPTY = 4'd12;
  localparam logic [ST_W-1:0] ST_HOOK = 4'd13;

  localparam logic [KIND_W-1:0] KIND_NOP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_W8 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_W16 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_W32 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COND = 3'd4;

  // control that travels with each beat through the cipher stages
  typedef struct packed {
    logic valid;
    logic raw;
  } cldd_ctl_t;

  // region is bits 27:24 of the 28-bit bus address
  function automatic logic region_ok(input logic [3:0] rgn, input logic is_write);
    logic ok;
    ok = (rgn >= 4'h2) && (rgn <= 4'h7);
    if (is_write && ((rgn == 4'hE) || (rgn == 4'hF))) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic hook_ok(input logic [31:0] v);
    return (v == 32'h1) || (v == 32'h2) || (v == 32'h3) ||
           (v == 32'h101) || (v == 32'h102) || (v == 32'h103);
  endfunction

endpackage

@@ design/cldd_half.sv @@
// inverse cipher half round: subtracts the mixed source word from the other word unless raw
module cldd_half (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cldd_pkg::cldd_ctl_t   in_ctl,
  input  logic [31:0]           src_word,
  input  logic [31:0]           dst_word,
  input  logic [31:0]           key_a,
  input  logic [31:0]           key_b,
  input  logic [31:0]           sum,
  output cldd_pkg::cldd_ctl_t   ctl_r,
  output logic [31:0]           src_r,
  output logic [31:0]           dst_r
);

  logic [31:0] mix;
  logic [31:0] dst_nxt;

  assign mix = ((src_word << 4) + key_a) ^ (src_word + sum) ^ ((src_word >> 5) + key_b);
  // raw lines pass through untouched
  assign dst_nxt = in_ctl.raw ? dst_word : (dst_word - mix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_word;
    dst_r <= dst_nxt;
  end

endmodule

@@ design/cldd_decode.sv @@
// decodes and validates one plain cheat line into a registered result beat
module cldd_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [31:0]                     left_word,
  input  logic [31:0]                     right_word,
  input  logic [cldd_pkg::ROM_W-1:0]      rom_bytes,
  output logic                            out_valid,
  output logic [cldd_pkg::ST_W-1:0]       out_status,
  output logic [cldd_pkg::KIND_W-1:0]     out_kind,
  output logic [cldd_pkg::ADDR_W-1:0]     out_target_address,
  output logic [31:0]                     out_operand_value,
  output logic [7:0]                      out_skip_count,
  output logic                            out_patch_valid,
  output logic [cldd_pkg::OFF_W-1:0]      out_patch_offset,
  output logic [15:0]                     out_patch_value
);

  logic [cldd_pkg::ST_W-1:0]   st_nxt;
  logic [cldd_pkg::KIND_W-1:0] kind_nxt;
  logic [cldd_pkg::ADDR_W-1:0] addr_nxt;
  logic [31:0]                 val_nxt;
  logic [7:0]                  cnt_nxt;
  logic                        pv_nxt;
  logic [cldd_pkg::OFF_W-1:0]  poff_nxt;
  logic [15:0]                 pval_nxt;
  logic [3:0]                  line_type;
  logic [cldd_pkg::ADDR_W-1:0] addr;
  logic [cldd_pkg::ROM_W-1:0]  patch_last;
  logic [cldd_pkg::ADDR_W-1:0] multi_addr;

  assign line_type = left_word[31:28];
  assign addr = left_word[27:0];
  // offset + 1 of the patched halfword, always odd
  assign patch_last = {1'b0, left_word[23:0], 1'b1};
  assign multi_addr = right_word[27:0];

  always_comb begin
    st_nxt = cldd_pkg::ST_OK;
    kind_nxt = cldd_pkg::KIND_NOP;
    addr_nxt = '0;
    val_nxt = '0;
    cnt_nxt = '0;
    pv_nxt = 1'b0;
    poff_nxt = '0;
    pval_nxt = '0;
    if (left_word == cldd_pkg::MASTER_MARK) begin
      st_nxt = cldd_pkg::ST_MASTER;
    end else if (right_word == cldd_pkg::GAME_ID_MARK) begin
      st_nxt = cldd_pkg::ST_OK;
    end else begin
      unique case (line_type)
        cldd_pkg::TYPE_W8: begin
          if (right_word[31:8] != '0) begin
            st_nxt = cldd_pkg::ST_WIDE;
          end else if (!cldd_pkg::region_ok(addr[27:24], 1'b1)) begin
            st_nxt = cldd_pkg::ST_WADDR;
          end else begin
            kind_nxt = cldd_pkg::KIND_W8;
            addr_nxt = addr;
            val_nxt = right_word;
          end
        end
        cldd_pkg::TYPE_W16: begin
          if (right_word[31:16] != '0) begin
            st_nxt = cldd_pkg::ST_WIDE;
          end else if (addr[0] || !cldd_pkg::region_ok(addr[27:24], 1'b1)) begin
            st_nxt = cldd_pkg::ST_WADDR;
          end else begin
            kind_nxt = cldd_pkg::KIND_W16;
            addr_nxt = addr;
            val_nxt = right_word;
          end
        end
        cldd_pkg::TYPE_W32: begin
          if ((addr[1:0] != 2'b00) || !cldd_pkg::region_ok(addr[27:24], 1'b1)) begin
            st_nxt = cldd_pkg::ST_WADDR;
          end else begin
            kind_nxt = cldd_pkg::KIND_W32;
            addr_nxt = addr;
            val_nxt = right_word;
          end
        end
        cldd_pkg::TYPE_GROUP: begin
          st_nxt = cldd_pkg::ST_GROUP;
        end
        cldd_pkg::TYPE_PATCH: begin
          if ((left_word[27:24] != 4'h0) || (right_word[31:29] != 3'b000) ||
              (right_word[27:16] != '0)) begin
            st_nxt = cldd_pkg::ST_PTYPE;
          end else if (patch_last >= rom_bytes) begin
            st_nxt = cldd_pkg::ST_PRANGE;
          end else begin
            pv_nxt = 1'b1;
            poff_nxt = {left_word[23:0], 1'b0};
            pval_nxt = right_word[15:0];
          end
        end
        cldd_pkg::TYPE_BUTTON: begin
          if ((left_word[31:20] == cldd_pkg::BUTTON_TOP_A) ||
              (left_word[31:20] == cldd_pkg::BUTTON_TOP_B) ||
              (left_word == cldd_pkg::BUTTON_LINE)) begin
            st_nxt = cldd_pkg::ST_BUTTON;
          end else begin
            st_nxt = cldd_pkg::ST_UNKNOWN;
          end
        end
        cldd_pkg::TYPE_COND: begin
          if (right_word[31:16] != '0) begin
            st_nxt = cldd_pkg::ST_CVALUE;
          end else if (addr[0] || !cldd_pkg::region_ok(addr[27:24], 1'b0)) begin
            st_nxt = cldd_pkg::ST_CADDR;
          end else begin
            kind_nxt = cldd_pkg::KIND_COND;
            addr_nxt = addr;
            val_nxt = right_word;
            cnt_nxt = 8'd1;
          end
        end
        cldd_pkg::TYPE_COND_MULTI: begin
          if ((left_word[31:24] != cldd_pkg::COND_MULTI_TOP) || (right_word[31:28] != 4'h0)) begin
            st_nxt = cldd_pkg::ST_CCMD;
          end else if (left_word[23:16] == 8'd0) begin
            st_nxt = cldd_pkg::ST_CEMPTY;
          end else if (multi_addr[0] || !cldd_pkg::region_ok(multi_addr[27:24], 1'b0)) begin
            st_nxt = cldd_pkg::ST_CADDR;
          end else begin
            kind_nxt = cldd_pkg::KIND_COND;
            addr_nxt = multi_addr;
            val_nxt = {16'h0000, left_word[15:0]};
            cnt_nxt = left_word[23:16];
          end
        end
        cldd_pkg::TYPE_HOOK: begin
          if ((addr[27:25] != cldd_pkg::HOOK_SPACE) || !cldd_pkg::hook_ok(right_word)) begin
            st_nxt = cldd_pkg::ST_HOOK;
          end
        end
        default: begin
          st_nxt = cldd_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= st_nxt;
    out_kind <= kind_nxt;
    out_target_address <= addr_nxt;
    out_operand_value <= val_nxt;
    out_skip_count <= cnt_nxt;
    out_patch_valid <= pv_nxt;
    out_patch_offset <= poff_nxt;
    out_patch_value <= pval_nxt;
  end

endmodule

@@ design/cheat_line_decrypt_decode_core.sv @@
// top level: cheat line decrypt pipeline, decode stage and configuration registers
//
// usage
//   input: a line is taken at a rising edge with start high and busy low; busy stays
//   low, so a new line can be issued every cycle. in_raw_line set skips decryption.
//   result: each line gives exactly one beat, out_valid high for one cycle with all
//   out_ fields; the receiver must take it in that cycle.
//   config: cfg_we with cfg_index 0..3 loads the cipher keys, 4 loads the rom size;
//   other indexes are dropped. write only while no line is in flight.
// pipeline
//   each round is split into two half-round register stages, followed by one decode
//   register. throughput is one line per cycle; raw lines take the same path and latency.
// reset
//   rst_n low clears every stage valid bit, so lines in flight are dropped, and loads
//   the default keys and a rom size of zero (every patch line then fails its range check).
module cheat_line_decrypt_decode_core #(
  parameter int unsigned CIPHER_ROUNDS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       in_left_word,
  input  logic [31:0]                       in_right_word,
  input  logic                              in_raw_line,
  output logic                              out_valid,
  output logic [cldd_pkg::ST_W-1:0]         out_status,
  output logic [cldd_pkg::KIND_W-1:0]       out_kind,
  output logic [cldd_pkg::ADDR_W-1:0]       out_target_address,
  output logic [31:0]                       out_operand_value,
  output logic [7:0]                        out_skip_count,
  output logic                              out_patch_valid,
  output logic [cldd_pkg::OFF_W-1:0]        out_patch_offset,
  output logic [15:0]                       out_patch_value,
  input  logic                              cfg_we,
  input  logic [cldd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int unsigned STAGES = 2 * CIPHER_ROUNDS;

  logic [31:0] key0_r;
  logic [31:0] key1_r;
  logic [31:0] key2_r;
  logic [31:0] key3_r;
  logic [cldd_pkg::ROM_W-1:0] rom_bytes_r;

  cldd_pkg::cldd_ctl_t ctl_s [0:STAGES];
  logic [31:0] y_s [0:STAGES];
  logic [31:0] z_s [0:STAGES];

  // every stage advances each cycle, nothing ever holds the input off
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= cldd_pkg::KEY0_RST;
      key1_r <= cldd_pkg::KEY1_RST;
      key2_r <= cldd_pkg::KEY2_RST;
      key3_r <= cldd_pkg::KEY3_RST;
      rom_bytes_r <= cldd_pkg::ROM_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cldd_pkg::CFG_KEY0:      key0_r <= cfg_data;
        cldd_pkg::CFG_KEY1:      key1_r <= cfg_data;
        cldd_pkg::CFG_KEY2:      key2_r <= cfg_data;
        cldd_pkg::CFG_KEY3:      key3_r <= cfg_data;
        cldd_pkg::CFG_ROM_BYTES: rom_bytes_r <= cfg_data[cldd_pkg::ROM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ctl_s[0] = '{valid: start && !busy, raw: in_raw_line};
  assign y_s[0] = in_left_word;
  assign z_s[0] = in_right_word;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    // rounds run from CIPHER_ROUNDS down to 1, sum = round * delta mod 2^32
    localparam int unsigned ROUND = CIPHER_ROUNDS - (g / 2);
    localparam logic [63:0] PROD = 64'(ROUND) * 64'(cldd_pkg::TEA_DELTA);
    localparam logic [31:0] SUM = PROD[31:0];

    if ((g % 2) == 0) begin : g_right
      cldd_half u_half (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl_s[g]),
        .src_word (y_s[g]),
        .dst_word (z_s[g]),
        .key_a    (key2_r),
        .key_b    (key3_r),
        .sum      (SUM),
        .ctl_r    (ctl_s[g+1]),
        .src_r    (y_s[g+1]),
        .dst_r    (z_s[g+1])
      );
    end else begin : g_left
      cldd_half u_half (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl_s[g]),
        .src_word (z_s[g]),
        .dst_word (y_s[g]),
        .key_a    (key0_r),
        .key_b    (key1_r),
        .sum      (SUM),
        .ctl_r    (ctl_s[g+1]),
        .src_r    (z_s[g+1]),
        .dst_r    (y_s[g+1])
      );
    end
  end

  cldd_decode u_decode (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (ctl_s[STAGES].valid),
    .left_word          (y_s[STAGES]),
    .right_word         (z_s[STAGES]),
    .rom_bytes          (rom_bytes_r),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_kind           (out_kind),
    .out_target_address (out_target_address),
    .out_operand_value  (out_operand_value),
    .out_skip_count     (out_skip_count),
    .out_patch_valid    (out_patch_valid),
    .out_patch_offset   (out_patch_offset),
    .out_patch_value    (out_patch_value)
  );

  // a beat leaving the last cipher stage shows up as a result next cycle
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[STAGES].valid |=> out_valid)
    else $error("cipher stage beat did not reach the result port");

  // error beats carry no action
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != cldd_pkg::ST_OK)) |->
      ((out_kind == cldd_pkg::KIND_NOP) && (out_target_address == '0) &&
       (out_operand_value == '0) && (out_skip_count == '0) && !out_patch_valid &&
       (out_patch_offset == '0) && (out_patch_value == '0)))
    else $error("error result carries nonzero fields");

  // a patch is never also a write or a condition
  a_patch_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_patch_valid) |->
      ((out_kind == cldd_pkg::KIND_NOP) && (out_status == cldd_pkg::ST_OK) &&
       (out_target_address == '0) && (out_operand_value == '0)))
    else $error("patch result mixed with another action");

  // a condition always skips at least one line
  a_cond_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == cldd_pkg::KIND_COND)) |->
      ((out_skip_count != 8'd0) && (out_operand_value[31:16] == 16'h0000)))
    else $error("condition result with empty count or wide value");

endmodule
